// File: sv/npc_pkg.sv
// Shared constants and types of the near-plane polygon clipper.
// No dependencies; the clipper top, the divider, the blend unit and the testbench import this package.
package npc_pkg;

    localparam int MAX_VERTS = 8;
    localparam int NATTR     = 9;
    localparam int STORE_CAP = MAX_VERTS + 1;
    localparam int ATTR_Z    = 2;
    localparam int U_SHIFT   = 30;
    localparam int DIV_STEPS = U_SHIFT + 1;

    localparam int CNT_W  = $clog2(STORE_CAP + 1);
    localparam int ADDR_W = $clog2(STORE_CAP);
    localparam int LOAD_W = $clog2(MAX_VERTS + 1);
    localparam int IDX_W  = $clog2(NATTR);
    localparam int STEP_W = $clog2(DIV_STEPS + 1);
    localparam int U_W    = U_SHIFT + 1;
    localparam int MAG_W  = 33;
    localparam int PROD_W = MAG_W + U_W;

    localparam logic signed [31:0] NEAR_Z_RESET = 32'sd65536;
    localparam logic [U_W-1:0]     U_ONE        = U_W'(1) << U_SHIFT;

    typedef logic [NATTR-1:0][31:0] t_vtx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: sv/npc_if.sv
// Channel interfaces of the near-plane polygon clipper: vertex in, clipped vertex out
// and the near-plane register write. No dependencies.
interface npc_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_w;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
    logic signed [31:0] col_r;
    logic signed [31:0] col_g;
    logic signed [31:0] col_b;
    logic               last_vertex;

    modport source (output valid, pos_x, pos_y, pos_z, pos_w, tex_s, tex_t,
                    col_r, col_g, col_b, last_vertex, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, pos_w, tex_s, tex_t,
                    col_r, col_g, col_b, last_vertex, output ready);
endinterface

interface npc_clip_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic signed [31:0] out_s;
    logic signed [31:0] out_t;
    logic signed [31:0] out_r;
    logic signed [31:0] out_g;
    logic signed [31:0] out_b;
    logic               last_of_polygon;

    modport source (output valid, out_x, out_y, out_z, out_w, out_s, out_t,
                    out_r, out_g, out_b, last_of_polygon, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, out_s, out_t,
                    out_r, out_g, out_b, last_of_polygon, output ready);
endinterface

interface npc_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] near_z;

    modport source (output valid, near_z, input ready);
    modport sink   (input valid, near_z, output ready);
endinterface

// File: sv/near_plane_polygon_clipper.sv
// Top level of the near-plane polygon clipper: sequencer, vertex registers and buffer.
// Depends on npc_pkg, npc_if, npc_divider and npc_blend.
//
// Vertices of a polygon enter on i_vtx, one request each, the final one with
// last_vertex set. i_vtx.ready is high only while the block is idle. A vertex
// whose edge stays on one side of the plane needs no division; an edge that
// crosses the plane passes through the divider that forms the clip parameter,
// then through the shared interpolation unit, one attribute at a time.
// On the last vertex the closing edge is clipped the same way; then, if at
// least three vertices were kept, they leave on o_clip one at a time, each
// read from the buffer before it is offered, the last one flagged by
// last_of_polygon. A stalled receiver simply holds the current request on
// o_clip until ready returns. The near plane is written on i_cfg, which is always
// ready; write it only while the block is idle. Reset returns the sequencer to
// idle, empties the vertex buffer and sets the near plane to 1.0.
module near_plane_polygon_clipper import npc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npc_vtx_if.sink     i_vtx,
    npc_clip_if.source  o_clip,
    npc_cfg_if.sink     i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CLOSE, S_EDGE, S_DIV, S_MUL, S_ACC,
        S_STMID, S_STV1, S_DONE, S_RD, S_OUT
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_near;
    t_vtx               r_cur, r_first, r_prev, r_e0, r_e1, r_mid;
    logic               r_last, r_close, r_out0;
    logic [CNT_W-1:0]   r_clip_cnt;
    logic [LOAD_W-1:0]  r_load_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic [ADDR_W-1:0]  r_k;
    logic [U_W-1:0]     r_u;

    t_vtx               mem [STORE_CAP];
    t_vtx               r_rd_data;

    logic               out0, out1, wr_req, wr_en, div_start;
    logic [MAG_W-1:0]   num, den, anum, aden;
    t_div_stat          div_stat;
    logic [U_W-1:0]     div_quot;
    logic [31:0]        blend_res;

    assign out0 = $signed(r_e0[ATTR_Z]) < r_near;
    assign out1 = $signed(r_e1[ATTR_Z]) < r_near;
    assign num  = {r_near[31], r_near} - {r_e0[ATTR_Z][31], r_e0[ATTR_Z]};
    assign den  = {r_e1[ATTR_Z][31], r_e1[ATTR_Z]} - {r_e0[ATTR_Z][31], r_e0[ATTR_Z]};
    assign anum = num[MAG_W-1] ? (~num + 1'b1) : num;
    assign aden = den[MAG_W-1] ? (~den + 1'b1) : den;

    assign div_start = (r_state == S_EDGE) && (out0 != out1);
    assign wr_req    = ((r_state == S_EDGE) && !out0 && !out1)
                    || (r_state == S_STMID) || (r_state == S_STV1);
    assign wr_en     = wr_req && (r_clip_cnt < CNT_W'(STORE_CAP));

    npc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (anum),
        .i_den   (aden),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    npc_blend u_blend (
        .i_clk (i_clk),
        .i_go  (r_state == S_MUL),
        .i_a0  (r_e0[r_idx]),
        .i_a1  (r_e1[r_idx]),
        .i_u   (r_u),
        .o_res (blend_res)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_clip_cnt[ADDR_W-1:0]] <= (r_state == S_STMID) ? r_mid : r_e1;
        end
        if (r_state == S_RD) begin
            r_rd_data <= mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_near     <= NEAR_Z_RESET;
            r_clip_cnt <= '0;
            r_load_cnt <= '0;
            r_idx      <= '0;
            r_k        <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_near <= i_cfg.near_z;
            end
            if (wr_en) begin
                r_clip_cnt <= r_clip_cnt + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_vtx.valid) begin
                        r_cur[0] <= i_vtx.pos_x;
                        r_cur[1] <= i_vtx.pos_y;
                        r_cur[2] <= i_vtx.pos_z;
                        r_cur[3] <= i_vtx.pos_w;
                        r_cur[4] <= i_vtx.tex_s;
                        r_cur[5] <= i_vtx.tex_t;
                        r_cur[6] <= i_vtx.col_r;
                        r_cur[7] <= i_vtx.col_g;
                        r_cur[8] <= i_vtx.col_b;
                        r_last   <= i_vtx.last_vertex;
                        r_state  <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_load_cnt == '0) begin
                        r_first    <= r_cur;
                        r_prev     <= r_cur;
                        r_load_cnt <= LOAD_W'(1);
                        r_state    <= r_last ? S_CLOSE : S_IDLE;
                    end else if (r_load_cnt < LOAD_W'(MAX_VERTS)) begin
                        r_e0    <= r_prev;
                        r_e1    <= r_cur;
                        r_close <= 1'b0;
                        r_state <= S_EDGE;
                    end else begin
                        r_state <= r_last ? S_CLOSE : S_IDLE;
                    end
                end
                S_CLOSE: begin
                    r_e0    <= r_prev;
                    r_e1    <= r_first;
                    r_close <= 1'b1;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_out0 <= out0;
                    if (out0 == out1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_u     <= div_quot;
                        r_idx   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_mid[r_idx] <= blend_res;
                    if (r_idx == IDX_W'(NATTR - 1)) begin
                        r_state <= S_STMID;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_STMID: begin
                    r_state <= r_out0 ? S_STV1 : S_DONE;
                end
                S_STV1: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_close) begin
                        r_k <= '0;
                        if (r_clip_cnt >= CNT_W'(3)) begin
                            r_state <= S_RD;
                        end else begin
                            r_clip_cnt <= '0;
                            r_load_cnt <= '0;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_prev     <= r_cur;
                        r_load_cnt <= r_load_cnt + 1'b1;
                        r_state    <= r_last ? S_CLOSE : S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_clip.ready) begin
                        if (CNT_W'(r_k) + 1'b1 == r_clip_cnt) begin
                            r_clip_cnt <= '0;
                            r_load_cnt <= '0;
                            r_state    <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_vtx.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_clip.valid           = (r_state == S_OUT);
    assign o_clip.out_x           = r_rd_data[0];
    assign o_clip.out_y           = r_rd_data[1];
    assign o_clip.out_z           = r_rd_data[2];
    assign o_clip.out_w           = r_rd_data[3];
    assign o_clip.out_s           = r_rd_data[4];
    assign o_clip.out_t           = r_rd_data[5];
    assign o_clip.out_r           = r_rd_data[6];
    assign o_clip.out_g           = r_rd_data[7];
    assign o_clip.out_b           = r_rd_data[8];
    assign o_clip.last_of_polygon = (CNT_W'(r_k) + 1'b1 == r_clip_cnt);

    a_emit_enough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clip.valid |-> r_clip_cnt >= CNT_W'(3))
        else $error("clipped polygon emitted with fewer than three vertices");

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip_cnt <= CNT_W'(STORE_CAP))
        else $error("clipped vertex count beyond buffer capacity");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt <= LOAD_W'(MAX_VERTS))
        else $error("loaded vertex count beyond limit");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_vtx.ready && o_clip.valid))
        else $error("vertex accepted while emitting");

endmodule

// File: sv/npc_divider.sv
// Restoring divider that forms the clip parameter u = (num << 30) / den, one bit a cycle.
// Depends on npc_pkg.
module npc_divider import npc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_num,
    input  logic [MAG_W-1:0]  i_den,
    output t_div_stat         o_stat,
    output logic [U_W-1:0]    o_quot
);

    logic [MAG_W:0]    r_rem;
    logic [MAG_W-1:0]  r_den;
    logic [U_W-1:0]    r_q;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              ge;
    logic [MAG_W:0]    rem_sub;

    assign ge      = r_rem >= {1'b0, r_den};
    assign rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= STEP_W'(DIV_STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[U_W-2:0], ge};
                r_rem <= {rem_sub[MAG_W-1:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot = (r_den == '0) ? '0 : ((r_q > U_ONE) ? U_ONE : r_q);

endmodule

// File: sv/npc_blend.sv
// Shared lerp unit: registers |a1-a0|*u, rounds and adds to or subtracts from a0.
// Depends on npc_pkg.
module npc_blend import npc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_go,
    input  logic [31:0]        i_a0,
    input  logic [31:0]        i_a1,
    input  logic [U_W-1:0]     i_u,
    output logic [31:0]        o_res
);

    logic [PROD_W-1:0] r_prod;
    logic [31:0]       r_a0;
    logic              r_neg;
    logic [MAG_W-1:0]  d;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] rnd;
    logic [31:0]       p;

    assign d   = {i_a1[31], i_a1} - {i_a0[31], i_a0};
    assign mag = d[MAG_W-1] ? (~d + 1'b1) : d;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= PROD_W'(mag) * PROD_W'(i_u);
            r_a0   <= i_a0;
            r_neg  <= d[MAG_W-1];
        end
    end

    assign rnd   = r_prod + (PROD_W'(1) << (U_SHIFT - 1));
    assign p     = rnd[U_SHIFT +: 32];
    assign o_res = r_neg ? (r_a0 - p) : (r_a0 + p);

endmodule

// File: verif/tb_near_plane_polygon_clipper.sv
// Testbench of the near-plane polygon clipper: drives polygons, near-plane writes and
// checks every clipped vertex against a predictor of the Sutherland-Hodgman clip.
// Depends on npc_pkg, npc_if and near_plane_polygon_clipper.
`timescale 1ns / 1ps

class clip_scoreboard;
    typedef logic signed [31:0] t_attr [9];
    typedef struct {
        t_attr attr;
        logic  last;
    } t_clip_vtx;

    longint    near_z;
    longint    first_v [9];
    longint    prev_v [9];
    longint    kept [9][9];
    int        kept_cnt;
    int        loaded_cnt;
    t_clip_vtx pending_clips [$];
    int        errors;
    int        checked;
    int        polygons;

    function new();
        near_z = 65536;
        kept_cnt = 0;
        loaded_cnt = 0;
        errors = 0;
        checked = 0;
        polygons = 0;
    endfunction

    function void set_near(logic signed [31:0] z);
        near_z = z;
    endfunction

    function void keep(longint v [9]);
        if (kept_cnt < 9) begin
            for (int i = 0; i < 9; i++) kept[kept_cnt][i] = v[i];
            kept_cnt++;
        end
    endfunction

    function longint lerp(longint a0, longint a1, longint u);
        longint d;
        longint mag;
        longint p;
        d = a1 - a0;
        mag = (d < 0) ? -d : d;
        p = (mag * u + (64'sd1 <<< 29)) >>> 30;
        return (d < 0) ? a0 - p : a0 + p;
    endfunction

    function void clip_one_edge(longint v0 [9], longint v1 [9]);
        bit     out0;
        bit     out1;
        longint anum;
        longint aden;
        longint u;
        longint mid [9];
        out0 = v0[2] < near_z;
        out1 = v1[2] < near_z;
        if (out0 && out1) return;
        if (!out0 && !out1) begin
            keep(v1);
            return;
        end
        anum = near_z - v0[2];
        aden = v1[2] - v0[2];
        if (anum < 0) anum = -anum;
        if (aden < 0) aden = -aden;
        u = (aden == 0) ? 0 : (anum <<< 30) / aden;
        if (u > (64'sd1 <<< 30)) u = 64'sd1 <<< 30;
        for (int i = 0; i < 9; i++) mid[i] = lerp(v0[i], v1[i], u);
        keep(mid);
        if (out0) keep(v1);
    endfunction

    function void note_vertex(t_attr a, logic last);
        longint    cur [9];
        t_clip_vtx c;
        for (int i = 0; i < 9; i++) cur[i] = a[i];
        if (loaded_cnt == 0) begin
            first_v = cur;
            prev_v = cur;
            loaded_cnt = 1;
        end else if (loaded_cnt < npc_pkg::MAX_VERTS) begin
            clip_one_edge(prev_v, cur);
            prev_v = cur;
            loaded_cnt++;
        end
        if (last) begin
            clip_one_edge(prev_v, first_v);
            if (kept_cnt >= 3) begin
                polygons++;
                for (int k = 0; k < kept_cnt; k++) begin
                    for (int i = 0; i < 9; i++) c.attr[i] = kept[k][i][31:0];
                    c.last = (k + 1 == kept_cnt);
                    pending_clips.push_back(c);
                end
            end
            kept_cnt = 0;
            loaded_cnt = 0;
        end
    endfunction

    function void check_clip(t_attr a, logic last);
        t_clip_vtx c;
        string     names [9] = '{"out_x", "out_y", "out_z", "out_w", "out_s", "out_t",
                                 "out_r", "out_g", "out_b"};
        if (pending_clips.size() == 0) begin
            $error("unexpected clipped vertex x=%0d", a[0]);
            errors++;
            return;
        end
        c = pending_clips.pop_front();
        checked++;
        for (int i = 0; i < 9; i++) begin
            if (a[i] !== c.attr[i]) begin
                $error("%s expected %0d actual %0d", names[i], c.attr[i], a[i]);
                errors++;
            end
        end
        if (last !== c.last) begin
            $error("last_of_polygon expected %0b actual %0b", c.last, last);
            errors++;
        end
    endfunction
endclass

module tb_near_plane_polygon_clipper;
    import npc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   hold_off;
    bit   stim_done;
    int   sent;
    clip_scoreboard board;

    npc_vtx_if  vtx ();
    npc_clip_if clip ();
    npc_cfg_if  cfg ();

    near_plane_polygon_clipper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .o_clip  (clip.source),
        .i_cfg   (cfg.sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_near_plane_polygon_clipper NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && clip.valid && clip.ready) begin
            board.check_clip('{clip.out_x, clip.out_y, clip.out_z, clip.out_w, clip.out_s,
                               clip.out_t, clip.out_r, clip.out_g, clip.out_b},
                             clip.last_of_polygon);
        end
        if (i_rst_n && vtx.valid && vtx.ready) begin
            board.note_vertex('{vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.pos_w, vtx.tex_s,
                                vtx.tex_t, vtx.col_r, vtx.col_g, vtx.col_b},
                              vtx.last_vertex);
        end
    end

    // Receiver: random stalls, or a long counted hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            clip.ready <= 1'b0;
        end else begin
            clip.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic write_near(logic signed [31:0] z);
        repeat (150) @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.near_z <= z;
        do @(posedge i_clk); while (!cfg.ready);
        board.set_near(z);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // The request stays up after acceptance; the block leaves idle on taking it, so
    // the next call replaces it before it could be taken again.
    task automatic send_vertex(logic signed [31:0] a [9], logic last);
        if ($urandom_range(99) < idle_pct) begin
            vtx.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        end
        vtx.valid <= 1'b1;
        {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.pos_w, vtx.tex_s} <= {a[0], a[1], a[2], a[3], a[4]};
        {vtx.tex_t, vtx.col_r, vtx.col_g, vtx.col_b} <= {a[5], a[6], a[7], a[8]};
        vtx.last_vertex <= last;
        do @(posedge i_clk); while (!vtx.ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        vtx.valid <= 1'b0;
        while (board.pending_clips.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 8) * 32'sd65536 - 32'sd262144;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sd131072;
        endcase
    endfunction

    // Polygon of random values; n vertices, last flag on the final one.
    task automatic send_polygon(int n, int mode);
        logic signed [31:0] a [9];
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 9; i++) a[i] = rand_word(($urandom_range(9) == 0) ? 0 : mode);
            send_vertex(a, k == n - 1);
        end
    endtask

    initial begin
        logic signed [31:0] a [9];
        logic signed [31:0] ext [4];
        board = new();
        idle_pct = 35;
        hold_off = 0;
        sent = 0;
        i_rst_n = 1'b0;
        vtx.valid = 1'b0;
        {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.pos_w, vtx.tex_s} = '0;
        {vtx.tex_t, vtx.col_r, vtx.col_g, vtx.col_b, vtx.last_vertex} = '0;
        clip.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.near_z = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: all inside, all outside, crossings, extremes, a one-vertex polygon.
        ext = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1};
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 9; i++) a[i] = ext[(k + i) % 4];
            send_vertex(a, k == 3);
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) a[i] = 32'sd200000 + k * 7;
            send_vertex(a, k == 2);
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) a[i] = -32'sd5 * k;
            send_vertex(a, k == 2);
        end
        for (int i = 0; i < 9; i++) a[i] = 32'sd77;
        send_vertex(a, 1'b1);
        // Eleven vertices: the extras beyond the load limit are dropped.
        send_polygon(11, 1);
        drain();

        // Long receiver hold-off with the sender still offering polygons.
        hold_off = 1500;
        send_polygon(6, 1);
        send_polygon(5, 2);
        drain();

        write_near(32'sh80000000);
        send_polygon(4, 0);
        drain();
        write_near(32'sh7fffffff);
        send_polygon(4, 0);
        send_vertex('{default: 32'sh7fffffff}, 1'b0);
        send_vertex('{default: 32'sh7fffffff}, 1'b0);
        send_vertex('{default: 32'sh7fffffff}, 1'b1);
        drain();
        write_near(32'sd0);

        while (sent < 175) begin
            if (sent > 100 && sent < 140) idle_pct = 0;
            else idle_pct = 35;
            if ($urandom_range(9) == 0) begin
                drain();
                write_near($urandom_range(3) == 0 ? $urandom() : rand_word(1));
            end
            send_polygon($urandom_range(3, 9), $urandom_range(2) == 0 ? 1 : 2);
        end
        drain();
        repeat (200) @(negedge i_clk);

        $display("Sent %0d vertices; %0d polygons emitted, %0d clipped vertices checked.",
                 sent, board.polygons, board.checked);
        if (board.errors == 0 && board.pending_clips.size() == 0) begin
            $display("tb_near_plane_polygon_clipper OK");
        end else begin
            $display("tb_near_plane_polygon_clipper NOT OK");
        end
        $finish;
    end
endmodule

// File: files.f
sv/npc_pkg.sv
sv/npc_if.sv
sv/npc_divider.sv
sv/npc_blend.sv
sv/near_plane_polygon_clipper.sv
verif/tb_near_plane_polygon_clipper.sv
